// ===== hw/rtl/kdbr_pkg.sv =====
// ---------------------------------------------------------------------------
// kdbr_pkg: shared types and constants of the key digit bin router
// Field widths, request codes, register indexes and the result layout.
// ---------------------------------------------------------------------------
`default_nettype none

package kdbr_pkg;

    localparam int unsigned BIN_IDX_W  = 4;
    localparam int unsigned SLOT_W     = 10;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_ELEMENT = 1'b0;
    localparam logic REQ_FINISH  = 1'b1;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        CFG_DIGIT_SHIFT = 2'd0,
        CFG_BIN_BITS    = 2'd1,
        CFG_DUMMY_VALUE = 2'd2
    } t_cfg_reg;

    // Result payload, last member in the lowest bits.
    typedef struct packed {
        logic                 overflow;
        logic [COUNT_W-1:0]   pad_count;
        logic [COUNT_W-1:0]   fill_count;
        logic [KEY_W-1:0]     out_key;
        logic [VALUE_W-1:0]   out_value;
        logic [SLOT_W-1:0]    slot_index;
        logic [BIN_IDX_W-1:0] bin_index;
    } t_result;

endpackage : kdbr_pkg

`default_nettype wire

// ===== hw/rtl/key_digit_bin_router_unit.sv =====
// ---------------------------------------------------------------------------
// key_digit_bin_router_unit: merge-split router of a bucket oblivious sort
// Routes elements to bins by a digit of their key, drops dummy elements,
// tracks per-bin fill and reports per-bin fill and pad counts on a finish request.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Contents
//  ---------+-----------+------------------------+--------------------------------
//  s_axis   | in        | tvalid / tready        | element or finish request
//  m_axis   | out       | tvalid / tready        | routed element or bin summary
//  apb      | in        | psel / penable, pready | digit_shift, bin_bits, dummy
//
//  An element request passes through the input stage and then the result
//  register; a new request can enter every cycle while m_axis does not stall.
//  A finish request holds the input stage while it emits one summary per
//  active bin (1 to 16 bins) from the fill counters, one per cycle unless m_axis stalls.
//  Reset is synchronous: fill counters clear; valid flags, summary index and
//  configuration registers take their reset values. A stall on m_axis holds the
//  result register and a non-dummy input; one request can still enter while a result waits.
//
`default_nettype none

module key_digit_bin_router_unit
    import kdbr_pkg::*;
#(
    parameter int MAX_BINS     = 16,
    parameter int BUCKET_DEPTH = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] element_value, [63:32] element_key
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  wire logic                   s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [3:0] bin_index, [13:4] slot_index, [45:14] out_value, [77:46] out_key,
    // [88:78] fill_count, [99:89] pad_count, [100] overflow, [103:101] zero
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] is_summary
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int NB      = (MAX_BINS < 16) ? MAX_BINS : 16;
    localparam int IDX_W   = $clog2(NB);
    localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
    localparam bit NB_POW2 = ((NB & (NB - 1)) == 0);

    // Weight of key nibble i modulo the bin count.
    function automatic int unsigned nib_weight(input int unsigned i);
        int unsigned p;
        p = 1;
        for (int unsigned j = 0; j < i; j++) begin
            p = (p * 16) % NB;
        end
        return p;
    endfunction

    localparam logic [3:0] NIB_W [8] = '{
        4'(nib_weight(0)), 4'(nib_weight(1)), 4'(nib_weight(2)), 4'(nib_weight(3)),
        4'(nib_weight(4)), 4'(nib_weight(5)), 4'(nib_weight(6)), 4'(nib_weight(7))
    };

    // Residue of a key modulo a bin count that is not a power of two:
    // fold the nibbles twice, then a binary run of compare and subtract.
    function automatic logic [IDX_W-1:0] mod_nb(input logic [KEY_W-1:0] x);
        logic [10:0] s1;
        logic [9:0]  r;
        s1 = '0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 11'(x[4*i +: 4]) * 11'(NIB_W[i]);
        end
        r = 10'(s1[3:0]) + 10'(s1[7:4]) * 10'(NIB_W[1]) + 10'(s1[10:8]) * 10'(NIB_W[2]);
        for (int k = 6; k >= 0; k--) begin
            if (r >= 10'(NB << k)) begin
                r = r - 10'(NB << k);
            end
        end
        return IDX_W'(r);
    endfunction

    // Configuration registers.
    logic [4:0]               r_digit_shift;
    logic [2:0]               r_bin_bits;
    logic signed [VALUE_W-1:0] r_dummy_value;

    // Input stage.
    logic                     r_in_valid;
    logic                     r_in_req;
    logic signed [VALUE_W-1:0] r_in_value;
    logic [KEY_W-1:0]         r_in_key;

    // Result register.
    logic                     r_out_valid;
    t_result                  r_res;
    logic                     r_out_summary;
    logic                     r_out_last;

    logic [FILL_W-1:0]        r_bin_fill [NB];
    logic [IDX_W-1:0]         r_sum_idx;

    logic [2:0]               bits_eff;
    logic [4:0]               bins_pow;
    logic                     bins_cap;
    logic [4:0]               bins_n;
    logic [KEY_W-1:0]         key_shifted;
    logic [IDX_W-1:0]         digit;
    logic                     is_finish;
    logic                     is_dummy;
    logic [IDX_W-1:0]         rd_addr;
    logic [FILL_W-1:0]        rd_fill;
    logic                     bin_full;
    logic [FILL_W-1:0]        pad_val;
    logic                     sum_last;
    logic                     out_free;
    logic                     emit;
    logic                     in_done;
    logic                     fin_step;
    logic                     fill_inc;
    logic                     cfg_wr;
    t_result                  n_res;
    logic                     n_out_last;

    assign bits_eff = (r_bin_bits > 3'd4) ? 3'd4 : r_bin_bits;
    assign bins_pow = 5'd1 << bits_eff;
    assign bins_cap = bins_pow > 5'(NB);
    assign bins_n   = bins_cap ? 5'(NB) : bins_pow;

    assign key_shifted = r_in_key >> r_digit_shift;

    always_comb begin
        if (bins_cap && !NB_POW2) begin
            digit = mod_nb(key_shifted);
        end else begin
            digit = IDX_W'(key_shifted & KEY_W'(bins_n - 5'd1));
        end
    end

    assign is_finish = (r_in_req == REQ_FINISH);
    assign is_dummy  = !is_finish && (r_in_value == r_dummy_value);
    assign rd_addr   = is_finish ? r_sum_idx : digit;
    assign rd_fill   = r_bin_fill[rd_addr];
    assign bin_full  = rd_fill >= FILL_W'(BUCKET_DEPTH);
    assign pad_val   = bin_full ? '0 : FILL_W'(BUCKET_DEPTH) - rd_fill;
    assign sum_last  = (5'(r_sum_idx) + 5'd1) == bins_n;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit      = r_in_valid && !is_dummy && out_free;
    assign fin_step  = r_in_valid && is_finish && out_free;
    assign fill_inc  = emit && !is_finish && !bin_full;
    assign in_done   = r_in_valid &&
                       (is_finish ? (out_free && sum_last) : (is_dummy || out_free));

    assign s_axis_tready = !r_in_valid || in_done;

    always_comb begin
        if (is_finish) begin
            n_res.bin_index  = BIN_IDX_W'(r_sum_idx);
            n_res.slot_index = '0;
            n_res.out_value  = '0;
            n_res.out_key    = '0;
            n_res.fill_count = COUNT_W'(rd_fill);
            n_res.pad_count  = COUNT_W'(pad_val);
            n_res.overflow   = 1'b0;
            n_out_last       = sum_last;
        end else begin
            n_res.bin_index  = BIN_IDX_W'(digit);
            n_res.slot_index = bin_full ? '0 : SLOT_W'(rd_fill);
            n_res.out_value  = r_in_value;
            n_res.out_key    = r_in_key;
            n_res.fill_count = '0;
            n_res.pad_count  = '0;
            n_res.overflow   = bin_full;
            n_out_last       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_idx   <= '0;
            for (int i = 0; i < NB; i++) begin
                r_bin_fill[i] <= '0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_req   <= s_axis_tuser;
                r_in_value <= s_axis_tdata[VALUE_W-1:0];
                r_in_key   <= s_axis_tdata[IN_DATA_W-1:VALUE_W];
            end else if (in_done) begin
                r_in_valid <= 1'b0;
            end

            if (out_free) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                r_res         <= n_res;
                r_out_summary <= is_finish;
                r_out_last    <= n_out_last;
            end

            if (fin_step) begin
                r_sum_idx <= sum_last ? '0 : r_sum_idx + IDX_W'(1);
            end

            if (fin_step && sum_last) begin
                for (int i = 0; i < NB; i++) begin
                    r_bin_fill[i] <= '0;
                end
            end else if (fill_inc) begin
                r_bin_fill[rd_addr] <= rd_fill + FILL_W'(1);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res};
    assign m_axis_tuser  = r_out_summary;
    assign m_axis_tlast  = r_out_last;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_shift <= 5'd0;
            r_bin_bits    <= 3'd1;
            r_dummy_value <= -32'sd1;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(paddr[3:2]))
                CFG_DIGIT_SHIFT: r_digit_shift <= pwdata[4:0];
                CFG_BIN_BITS:    r_bin_bits    <= pwdata[2:0];
                CFG_DUMMY_VALUE: r_dummy_value <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_cfg_reg'(paddr[3:2]))
            CFG_DIGIT_SHIFT: prdata = {27'd0, r_digit_shift};
            CFG_BIN_BITS:    prdata = {29'd0, r_bin_bits};
            CFG_DUMMY_VALUE: prdata = r_dummy_value;
            default:         prdata = '0;
        endcase
    end

    // A fill counter never goes past the bucket depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (rd_fill <= FILL_W'(BUCKET_DEPTH)))
        else $error("bin fill count above bucket depth");

    // Completing a finish leaves the first bin empty on the next cycle.
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_step && sum_last) |=> (r_bin_fill[0] == '0))
        else $error("fill counters not cleared after finish");

    // An overflowed element never carries a slot.
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_res.overflow) |-> (r_res.slot_index == '0 && !m_axis_tuser))
        else $error("overflow result with a slot or on a summary");

    // Only a summary closes a run.
    a_last_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("tlast on an element result");

endmodule : key_digit_bin_router_unit

`default_nettype wire
